/* hw/rtl/swm_pkg.sv */
// Shared constants, types and cell control structs for the sliding window median.
// No dependencies; every other file in hw/rtl imports this package.
package swm_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int IN_W        = 32;
  localparam int OUT_W       = 33;
  localparam int CFG_W       = 7;
  localparam int FILL_W      = $clog2(MAX_WINDOW + 1);
  localparam int AGE_W       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int IDX_W       = AGE_W;

  localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(3);

  typedef logic signed [SAMPLE_BITS-1:0] value_t;
  typedef logic [AGE_W-1:0]              age_t;
  typedef logic [IDX_W-1:0]              idx_t;
  typedef logic [FILL_W-1:0]             fill_t;

  // one slot of the sorted window
  typedef struct packed {
    logic   valid;
    value_t value;
    age_t   age;
  } entry_t;

  // per-cell status seen by both neighbors
  typedef struct packed {
    logic kept;      // survives this step's eviction/restart
    logic shift_dn;  // evicted slot lies below this cell
    logic gt;        // holds a value above the new sample
  } flags_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic   load;
    logic   clear;
    logic   restart;
    logic   evict;
    value_t value;
    age_t   oldest_age;
    idx_t   idx_lo;
    idx_t   idx_hi;
  } bcast_t;

endpackage

/* hw/rtl/swm_if.sv */
// Valid/ready channel interfaces for samples in and medians out.
// Depends on swm_pkg for payload widths.
interface swm_sample_if;
  import swm_pkg::*;
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] sample;
  logic                   restart;
  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

interface swm_result_if;
  import swm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] median_x2;
  modport source (output valid, output median_x2, input ready);
  modport sink   (input valid, input median_x2, output ready);
endinterface

/* hw/rtl/swm_cell.sv */
// One slot of the sorted window: evicts, shifts and inserts in a single step.
// Depends on swm_pkg; instanced in a row by sliding_window_median.
module swm_cell (
  input  logic            clk,
  input  logic            rst,
  input  swm_pkg::idx_t   pos,
  input  swm_pkg::bcast_t bc,
  input  swm_pkg::entry_t left_ent,
  input  swm_pkg::flags_t left_flg,
  input  swm_pkg::entry_t right_ent,
  input  swm_pkg::flags_t right_flg,
  input  logic            rm_below_in,
  output logic            rm_below_out,
  input  logic            ln_left,
  output logic            ln_out,
  output swm_pkg::entry_t ent,
  output swm_pkg::flags_t flg,
  output swm_pkg::value_t lo_val,
  output swm_pkg::value_t hi_val
);
  import swm_pkg::*;

  logic   rm;
  logic   take_left, take_self, take_right, take_new;
  entry_t ent_next;

  assign rm           = bc.evict && ent.valid && (ent.age == bc.oldest_age);
  assign flg.kept     = ent.valid && !bc.restart && !rm;
  assign flg.shift_dn = rm_below_in;
  assign flg.gt       = ent.value > bc.value;
  assign rm_below_out = rm_below_in | rm;

  // ln: this slot ends up holding a surviving entry not above the new sample
  assign ln_out = (flg.kept && !flg.shift_dn && !flg.gt) ||
                  (right_flg.kept && right_flg.shift_dn && !right_flg.gt);

  assign take_left  = left_flg.kept && !left_flg.shift_dn && left_flg.gt;
  assign take_self  = flg.kept && (flg.shift_dn == flg.gt);
  assign take_right = right_flg.kept && right_flg.shift_dn && !right_flg.gt;
  assign take_new   = ln_left && !ln_out;

  always_comb begin
    ent_next = ent;
    ent_next.valid = 1'b1;
    if (take_new) begin
      ent_next.value = bc.value;
      ent_next.age   = '0;
    end else if (take_left) begin
      ent_next.value = left_ent.value;
      ent_next.age   = left_ent.age + age_t'(1);
    end else if (take_self) begin
      ent_next.age   = ent.age + age_t'(1);
    end else if (take_right) begin
      ent_next.value = right_ent.value;
      ent_next.age   = right_ent.age + age_t'(1);
    end else begin
      ent_next.valid = 1'b0;
    end
  end

  // only the valid bit is reset; value and age follow every load
  always_ff @(posedge clk) begin
    if (rst || bc.clear) begin
      ent.valid <= 1'b0;
    end else if (bc.load) begin
      ent.valid <= ent_next.valid;
    end
    if (bc.load) begin
      ent.value <= ent_next.value;
      ent.age   <= ent_next.age;
    end
  end

  assign lo_val = (pos == bc.idx_lo) ? ent.value : '0;
  assign hi_val = (pos == bc.idx_hi) ? ent.value : '0;

endmodule

/* hw/rtl/sliding_window_median.sv */
// Running median over the last window_size samples, built as a sorted row of cells.
// A sample word is inserted into the cells, then its median word is registered.
// Step order: insert, then median select and add; no new word while one is pending.
// Synchronous active-high rst: window_size = 3, window empty, no word pending.
// Writing window_size empties the window. Depends on swm_pkg, swm_if, swm_cell.
module sliding_window_median (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [swm_pkg::CFG_W-1:0]  cfg_wdata,
  swm_sample_if.sink                 samples,
  swm_result_if.source               medians
);
  import swm_pkg::*;

  // configuration and fill tracking
  logic [CFG_W-1:0] window_size;
  fill_t            fill;
  fill_t            fill_next;
  fill_t            eff_w;
  logic             accept;
  logic             evict;

  // pipeline control: pend = an item sits in the select stage
  logic             pend;
  logic             emit;

  bcast_t           bc;
  idx_t             idx_hi;

  // chain wiring; slot i+1 of the padded arrays is cell i
  entry_t           ent_pad [MAX_WINDOW+2];
  flags_t           flg_pad [MAX_WINDOW+2];
  logic             rm_chain [MAX_WINDOW+1];
  logic             ln_chain [MAX_WINDOW+1];
  value_t           lo_vals [MAX_WINDOW];
  value_t           hi_vals [MAX_WINDOW];
  value_t           lo_sel, hi_sel;
  logic signed [SAMPLE_BITS:0] sum;

  // A zero size acts as 1, anything above the row length saturates.
  always_comb begin
    if (window_size == '0) begin
      eff_w = fill_t'(1);
    end else if (int'(window_size) > MAX_WINDOW) begin
      eff_w = fill_t'(MAX_WINDOW);
    end else begin
      eff_w = fill_t'(window_size);
    end
  end

  assign samples.ready = !pend && (!medians.valid || medians.ready);
  assign accept        = samples.valid && samples.ready;

  // Window full and no restart: the oldest entry (age w-1) leaves this step.
  assign evict     = !samples.restart && (fill == eff_w);
  assign fill_next = samples.restart ? fill_t'(1) :
                     evict           ? fill : fill + fill_t'(1);

  // Median slots: odd w uses the middle slot twice, even w the two middles.
  assign idx_hi = idx_t'(eff_w >> 1);

  always_comb begin
    bc.load       = accept;
    bc.clear      = cfg_we;
    bc.restart    = samples.restart;
    bc.evict      = evict;
    bc.value      = value_t'(samples.sample[SAMPLE_BITS-1:0]);
    bc.oldest_age = age_t'(eff_w - fill_t'(1));
    bc.idx_hi     = idx_hi;
    bc.idx_lo     = eff_w[0] ? idx_hi : idx_hi - idx_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_RESET;
      fill        <= '0;
    end else if (cfg_we) begin
      window_size <= cfg_wdata;
      fill        <= '0;
    end else if (accept) begin
      fill        <= fill_next;
    end
  end

  // ends of the row see empty neighbors; the first cell is the insert point
  // when nothing surviving lies at or below the new sample
  assign ent_pad[0]            = '0;
  assign flg_pad[0]            = '0;
  assign ent_pad[MAX_WINDOW+1] = '0;
  assign flg_pad[MAX_WINDOW+1] = '0;
  assign rm_chain[0]           = 1'b0;
  assign ln_chain[0]           = 1'b1;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    swm_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .pos          (idx_t'(i)),
      .bc           (bc),
      .left_ent     (ent_pad[i]),
      .left_flg     (flg_pad[i]),
      .right_ent    (ent_pad[i+2]),
      .right_flg    (flg_pad[i+2]),
      .rm_below_in  (rm_chain[i]),
      .rm_below_out (rm_chain[i+1]),
      .ln_left      (ln_chain[i]),
      .ln_out       (ln_chain[i+1]),
      .ent          (ent_pad[i+1]),
      .flg          (flg_pad[i+1]),
      .lo_val       (lo_vals[i]),
      .hi_val       (hi_vals[i])
    );
  end

  // Each cell drives zero unless it sits at a median slot; OR picks the values.
  always_comb begin
    lo_sel = '0;
    hi_sel = '0;
    for (int k = 0; k < MAX_WINDOW; k++) begin
      lo_sel = lo_sel | lo_vals[k];
      hi_sel = hi_sel | hi_vals[k];
    end
  end

  assign sum = {lo_sel[SAMPLE_BITS-1], lo_sel} + {hi_sel[SAMPLE_BITS-1], hi_sel};

  // select stage: in the cycle after the insert, the cells hold the new window
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      emit <= (fill_next == eff_w);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      medians.valid <= 1'b0;
    end else if (pend && emit) begin
      medians.valid <= 1'b1;
    end else if (medians.ready) begin
      medians.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend && emit) begin
      medians.median_x2 <= OUT_W'(sum);
    end
  end

endmodule
